[sv/cfd_pkg.sv]
// Package for the command frame deframer: word sizes, frame layout constants,
// status codes and the result word type. No dependencies.
package cfd_pkg;

  localparam int unsigned BODY_LIMIT = 256;
  localparam int unsigned HDR_LEN    = 12;
  localparam int unsigned OVF_INDEX  = 13 + BODY_LIMIT;
  localparam int unsigned IDX_W      = $clog2(OVF_INDEX + 1);
  localparam int unsigned OFF_W      = 9;

  localparam logic [7:0]  SYNC_RESET = 8'd126;

  typedef enum logic [2:0] {
    ST_BUSY  = 3'd0,
    ST_VALID = 3'd1,
    ST_SYNC  = 3'd2,
    ST_CSUM  = 3'd3,
    ST_OVER  = 3'd4
  } status_e;

  typedef struct packed {
    status_e          status;
    logic [7:0]       sensor_type;
    logic [31:0]      return_ip;
    logic [15:0]      return_port;
    logic [15:0]      frame_length;
    logic             body_strobe;
    logic [7:0]       body_byte;
    logic [OFF_W-1:0] body_offset;
  } res_t;

endpackage

[sv/cfd_in_if.sv]
// Input byte channel of the command frame deframer: valid/ready plus one byte
// word. Depends on nothing.
interface cfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_datagram;

  modport source (output valid, output data_byte, output first_of_datagram, input ready);
  modport sink   (input valid, input data_byte, input first_of_datagram, output ready);
endinterface

[sv/cfd_out_if.sv]
// Result channel of the command frame deframer: valid/ready plus the result
// word fields. Depends on nothing.
interface cfd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  sensor_type;
  logic [31:0] return_ip;
  logic [15:0] return_port;
  logic [15:0] frame_length;
  logic        body_strobe;
  logic [7:0]  body_byte;
  logic [8:0]  body_offset;

  modport source (output valid, output status, output sensor_type, output return_ip,
                  output return_port, output frame_length, output body_strobe,
                  output body_byte, output body_offset, input ready);
  modport sink   (input valid, input status, input sensor_type, input return_ip,
                  input return_port, input frame_length, input body_strobe,
                  input body_byte, input body_offset, output ready);
endinterface

[sv/command_frame_deframer_core.sv]
// Command frame deframer top level: parser state, result register and skid word.
// Depends on cfd_pkg, cfd_in_if and cfd_out_if.
//
// One result word per input word. Each byte is parsed combinationally by
// compare, byte insert and 8-bit add against the parser registers, and the
// result is registered in the output register, or in the skid register while
// a result waits; a new byte may be taken every cycle. A one-word skid register
// behind the output lets the input take one more byte; ready drops only
// when both are full. Sync errors, checksum errors and overflow (byte index
// 13 + BODY_LIMIT) clear the parser, as does first_of_datagram before its byte.
// sync_char resets to '~' and should be written only while the block is idle.
module command_frame_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfd_in_if.sink     in_i,
  cfd_out_if.source  out_o,
  input  logic       sync_char_we_i,
  input  logic [7:0] sync_char_i
);
  import cfd_pkg::*;

  logic [7:0]       sync_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       sensor_q, sensor_d;
  logic [31:0]      ip_q, ip_d;
  logic [15:0]      port_q, port_d;
  logic [15:0]      len_q, len_d;

  logic             out_valid_q, skid_valid_q;
  res_t             out_q, skid_q, res;

  logic             acc, pop;
  logic [IDX_W-1:0] idx_cur, off_full;
  logic [7:0]       sum_cur, b;
  logic [16:0]      idx_next_ext;
  logic             adv, clr;

  assign acc = in_i.valid && in_i.ready;
  assign pop = out_valid_q && out_o.ready;
  assign in_i.ready = !skid_valid_q;

  assign b            = in_i.data_byte;
  assign idx_cur      = in_i.first_of_datagram ? '0 : idx_q;
  assign sum_cur      = in_i.first_of_datagram ? '0 : sum_q;
  assign idx_next_ext = 17'(idx_cur) + 17'd1;
  assign off_full     = idx_cur - IDX_W'(HDR_LEN);

  always_comb begin
    res      = '0;
    res.status = ST_BUSY;
    adv      = 1'b1;
    clr      = 1'b0;
    sensor_d = sensor_q;
    ip_d     = ip_q;
    port_d   = port_q;
    len_d    = len_q;
    if (idx_cur <= IDX_W'(2)) begin
      if (b != sync_q) begin
        res.status = ST_SYNC;
        clr = 1'b1;
      end
    end else if (idx_cur <= IDX_W'(11)) begin
      case (idx_cur[3:0])
        4'd3:    sensor_d      = b;
        4'd4:    ip_d[31:24]   = b;
        4'd5:    ip_d[23:16]   = b;
        4'd6:    ip_d[15:8]    = b;
        4'd7:    ip_d[7:0]     = b;
        4'd8:    port_d[15:8]  = b;
        4'd9:    port_d[7:0]   = b;
        4'd10:   len_d[15:8]   = b;
        default: len_d[7:0]    = b;
      endcase
    end else if (idx_cur == IDX_W'(OVF_INDEX)) begin
      res.status = ST_OVER;
      clr = 1'b1;
    end else if (idx_next_ext == {1'b0, len_q}) begin
      clr = 1'b1;
      if (sum_cur == b) begin
        res.status       = ST_VALID;
        res.sensor_type  = sensor_q;
        res.return_ip    = ip_q;
        res.return_port  = port_q;
        res.frame_length = len_q;
      end else begin
        res.status = ST_CSUM;
      end
    end else begin
      res.body_strobe = 1'b1;
      res.body_byte   = b;
      res.body_offset = OFF_W'(off_full);
    end
    if (clr) adv = 1'b0;
    idx_d = adv ? idx_next_ext[IDX_W-1:0] : '0;
    sum_d = adv ? sum_cur + b : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= SYNC_RESET;
    end else if (sync_char_we_i) begin
      sync_q <= sync_char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      sum_q <= '0;
    end else if (acc) begin
      idx_q <= idx_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      sensor_q <= sensor_d;
      ip_q     <= ip_d;
      port_q   <= port_d;
      len_q    <= len_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || pop) begin
        out_valid_q <= skid_valid_q || acc;
      end
      if (skid_valid_q && pop) begin
        skid_valid_q <= 1'b0;
      end else if (acc && out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_q <= skid_valid_q ? skid_q : res;
    end
    if (acc && out_valid_q && !pop) begin
      skid_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_q.status;
  assign out_o.sensor_type  = out_q.sensor_type;
  assign out_o.return_ip    = out_q.return_ip;
  assign out_o.return_port  = out_q.return_port;
  assign out_o.frame_length = out_q.frame_length;
  assign out_o.body_strobe  = out_q.body_strobe;
  assign out_o.body_byte    = out_q.body_byte;
  assign out_o.body_offset  = out_q.body_offset;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held with empty output register");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_W'(OVF_INDEX))
    else $error("byte index beyond overflow point");

  a_hdr_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_VALID) |->
    (out_q.sensor_type == 8'd0 && out_q.return_ip == 32'd0 &&
     out_q.return_port == 16'd0 && out_q.frame_length == 16'd0))
    else $error("header fields reported without a valid frame");

  a_body_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.body_strobe) |-> out_q.status == ST_BUSY)
    else $error("body word with terminal status");

  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && res.status != ST_BUSY) |=> (idx_q == '0 && sum_q == 8'd0))
    else $error("parser not cleared after frame end");

endmodule
